// File: hw/rtl/btpc_pkg.sv
package btpc_pkg;

	typedef struct packed {
		logic [19:0] temperature_raw;
		logic [19:0] pressure_raw;
	} in_t;

	typedef struct packed {
		logic signed [31:0] fine_temperature;
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_pa;
		logic               pressure_valid;
	} out_t;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 48;

	typedef enum logic [CfgIdxW-1:0] {
		REG_T1   = 3'd0,
		REG_T2   = 3'd1,
		REG_T3   = 3'd2,
		REG_P1   = 3'd3,
		REG_P234 = 3'd4,
		REG_P56  = 3'd5,
		REG_P789 = 3'd6
	} reg_idx_t;

	localparam logic [31:0] PresOffset = 32'd64000;
	localparam logic [31:0] PresBase = 32'd1048576;
	localparam logic [31:0] PresScale = 32'd3125;
	localparam logic [31:0] DivBias = 32'd32768;
	localparam logic [31:0] RoundHalf = 32'd128;
	localparam logic [31:0] SignBit = 32'h8000_0000;

	// signed 16-bit word to 32 bits
	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

	// arithmetic right shift on a 32-bit word
	function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
		asr = 32'($signed(x) >>> n);
	endfunction

	// low 32 bits of a product
	function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] w;
		w = 64'(a) * 64'(b);
		mul = w[31:0];
	endfunction

endpackage

// File: hw/rtl/btpc_div.sv
// pipelined restoring divider, one quotient bit per stage
module btpc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_vld,
	input  logic [31:0] num,
	input  logic [31:0] den,
	input  logic        dbl,
	input  logic [95:0] side_in,
	output logic        out_vld,
	output logic [31:0] quo,
	output logic        dbl_out,
	output logic [95:0] side_out
);
	import btpc_pkg::*;

	localparam int N = 32;

	logic        vld_q  [N+1];
	logic [31:0] rem_q  [N+1];
	logic [31:0] q_q    [N+1];
	logic [31:0] den_q  [N+1];
	logic        dbl_q  [N+1];
	logic [95:0] side_q [N+1];

	always_comb begin
		vld_q[0]  = in_vld;
		rem_q[0]  = 32'd0;
		q_q[0]    = num;
		den_q[0]  = den;
		dbl_q[0]  = dbl;
		side_q[0] = side_in;
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [32:0] r;
		logic [32:0] d;
		always_comb begin
			r = {rem_q[i], q_q[i][31]};
			d = r - {1'b0, den_q[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (adv) begin
				vld_q[i+1] <= vld_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[i+1]  <= d[32] ? r[31:0] : d[31:0];
				q_q[i+1]    <= {q_q[i][30:0], ~d[32]};
				den_q[i+1]  <= den_q[i];
				dbl_q[i+1]  <= dbl_q[i];
				side_q[i+1] <= side_q[i];
			end
		end
	end

	assign out_vld  = vld_q[N];
	assign quo      = q_q[N];
	assign dbl_out  = dbl_q[N];
	assign side_out = side_q[N];
endmodule

// File: hw/rtl/baro_temp_pressure_compensation_core.sv
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | btpc_pkg::in_t
// out     | out | out_valid/out_ready | btpc_pkg::out_t
// cfg     | in  | cfg_we              | cfg_idx, cfg_data
// one request per cycle while the pipeline advances; the pipeline is made of
// the multiply stages with the 32-stage divider between them
// reset clears every stage valid bit and the calibration words
// the whole pipeline advances when the output register is empty or taken
module baro_temp_pressure_compensation_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  btpc_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output btpc_pkg::out_t                     out_data,
	input  logic                               cfg_we,
	input  logic [btpc_pkg::CfgIdxW-1:0]       cfg_idx,
	input  logic [btpc_pkg::CfgDataW-1:0]      cfg_data
);
	import btpc_pkg::*;

	// calibration registers
	logic [15:0] t1_q, t2_q, t3_q, p1_q;
	logic [47:0] p234_q, p789_q;
	logic [31:0] p56_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q <= '0; t2_q <= '0; t3_q <= '0; p1_q <= '0;
			p234_q <= '0; p56_q <= '0; p789_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_T1:   t1_q <= cfg_data[15:0];
				REG_T2:   t2_q <= cfg_data[15:0];
				REG_T3:   t3_q <= cfg_data[15:0];
				REG_P1:   p1_q <= cfg_data[15:0];
				REG_P234: p234_q <= cfg_data;
				REG_P56:  p56_q <= cfg_data[31:0];
				REG_P789: p789_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [31:0] ct1, ct2, ct3, cp1, cp2, cp3, cp4, cp5, cp6, cp7, cp8, cp9;
	assign ct1 = {16'd0, t1_q};
	assign ct2 = sx16(t2_q);
	assign ct3 = sx16(t3_q);
	assign cp1 = {16'd0, p1_q};
	assign cp2 = sx16(p234_q[15:0]);
	assign cp3 = sx16(p234_q[31:16]);
	assign cp4 = sx16(p234_q[47:32]);
	assign cp5 = sx16(p56_q[15:0]);
	assign cp6 = sx16(p56_q[31:16]);
	assign cp7 = sx16(p789_q[15:0]);
	assign cp8 = sx16(p789_q[31:16]);
	assign cp9 = sx16(p789_q[47:32]);

	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// s1: temperature products
	logic        v_s1;
	logic [31:0] ta_s1, dd_s1, dd0_s1, adcp_s1;
	always_comb dd0_s1 = 32'({12'd0, in_data.temperature_raw[19:4]}) - ct1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s1 <= asr(mul(32'({12'd0, in_data.temperature_raw[19:3]}) - (ct1 << 1),
				ct2), 11);
			dd_s1 <= mul(dd0_s1, dd0_s1);
			adcp_s1 <= {12'd0, in_data.pressure_raw};
		end
	end

	// s2: second temperature term
	logic        v_s2;
	logic [31:0] ta_s2, tb_s2, adcp_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s2 <= ta_s1;
			tb_s2 <= asr(mul(asr(dd_s1, 12), ct3), 14);
			adcp_s2 <= adcp_s1;
		end
	end

	// s3: fine temperature
	logic        v_s3;
	logic [31:0] fine_s3, adcp_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s3 <= ta_s2 + tb_s2;
			adcp_s3 <= adcp_s2;
		end
	end

	// s4: centi temperature and pressure offset
	logic        v_s4;
	logic [31:0] fine_s4, tc_s4, a_s4, adcp_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s4 <= fine_s3;
			tc_s4 <= asr(mul(fine_s3, 32'd5) + RoundHalf, 8);
			a_s4 <= asr(fine_s3, 1) - PresOffset;
			adcp_s4 <= adcp_s3;
		end
	end

	// s5: square and linear products
	logic        v_s5;
	logic [31:0] fine_s5, tc_s5, sq_s5, ap5_s5, ap2_s5, adcp_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s5 <= fine_s4; tc_s5 <= tc_s4; adcp_s5 <= adcp_s4;
			sq_s5 <= mul(asr(a_s4, 2), asr(a_s4, 2));
			ap5_s5 <= mul(a_s4, cp5);
			ap2_s5 <= mul(cp2, a_s4);
		end
	end

	// s6: products on the square
	logic        v_s6;
	logic [31:0] fine_s6, tc_s6, b6_s6, sp3_s6, ap5_s6, ap2_s6, adcp_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s6 <= fine_s5; tc_s6 <= tc_s5; adcp_s6 <= adcp_s5;
			b6_s6 <= mul(asr(sq_s5, 11), cp6);
			sp3_s6 <= mul(cp3, asr(sq_s5, 13));
			ap5_s6 <= ap5_s5; ap2_s6 <= ap2_s5;
		end
	end

	// s7: sums for offset and divisor term
	logic        v_s7;
	logic [31:0] fine_s7, tc_s7, b_s7, a_s7, adcp_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s7 <= fine_s6; tc_s7 <= tc_s6; adcp_s7 <= adcp_s6;
			b_s7 <= asr(b6_s6 + (ap5_s6 << 1), 2) + (cp4 << 16);
			a_s7 <= asr(asr(sp3_s6, 3) + asr(ap2_s6, 1), 18);
		end
	end

	// s8: divisor and numerator base
	logic        v_s8;
	logic [31:0] fine_s8, tc_s8, dv_s8, n_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s8 <= fine_s7; tc_s8 <= tc_s7;
			dv_s8 <= asr(mul(DivBias + a_s7, cp1), 15);
			n_s8 <= (PresBase - adcp_s7) - asr(b_s7, 12);
		end
	end

	// s9: numerator scale
	logic        v_s9;
	logic [31:0] fine_s9, tc_s9, dv_s9, n_s9;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (adv) v_s9 <= v_s8;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s9 <= fine_s8; tc_s9 <= tc_s8; dv_s9 <= dv_s8;
			n_s9 <= mul(n_s8, PresScale);
		end
	end

	// divider; a zero divisor is guarded by a substitute of one
	logic        dv_zero, dbl;
	logic [31:0] num, den;
	assign dv_zero = (dv_s9 == 32'd0);
	assign dbl = !(n_s9 < SignBit);
	assign num = dbl ? n_s9 : (n_s9 << 1);
	assign den = dv_zero ? 32'd1 : dv_s9;

	logic        v_d, dbl_d;
	logic [31:0] q_d;
	logic [95:0] side_d;
	btpc_div u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(v_s9),
		.num(num), .den(den), .dbl(dbl),
		.side_in({fine_s9, tc_s9, 31'd0, dv_zero}),
		.out_vld(v_d), .quo(q_d), .dbl_out(dbl_d), .side_out(side_d)
	);

	// s10: quotient
	logic        v_s10, z_s10;
	logic [31:0] fine_s10, tc_s10, p_s10;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (adv) v_s10 <= v_d;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s10 <= side_d[95:64]; tc_s10 <= side_d[63:32]; z_s10 <= side_d[0];
			p_s10 <= dbl_d ? (q_d << 1) : q_d;
		end
	end

	// s11: correction products
	logic        v_s11, z_s11;
	logic [31:0] fine_s11, tc_s11, p_s11, pp_s11, b_s11;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s11 <= 1'b0;
		else if (adv) v_s11 <= v_s10;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s11 <= fine_s10; tc_s11 <= tc_s10; z_s11 <= z_s10; p_s11 <= p_s10;
			pp_s11 <= mul(p_s10 >> 3, p_s10 >> 3);
			b_s11 <= asr(mul(p_s10 >> 2, cp8), 13);
		end
	end

	// s12: second correction product
	logic        v_s12, z_s12;
	logic [31:0] fine_s12, tc_s12, p_s12, a_s12, b_s12;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s12 <= 1'b0;
		else if (adv) v_s12 <= v_s11;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s12 <= fine_s11; tc_s12 <= tc_s11; z_s12 <= z_s11; p_s12 <= p_s11;
			a_s12 <= asr(mul(cp9, pp_s11 >> 13), 12);
			b_s12 <= b_s11;
		end
	end

	// output register
	logic out_valid_q;
	out_t out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= v_s12;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.fine_temperature  <= fine_s12;
			out_q.temperature_centi <= tc_s12;
			out_q.pressure_pa <= z_s12 ? 32'd0 :
				p_s12 + asr(a_s12 + b_s12 + cp7, 4);
			out_q.pressure_valid <= !z_s12;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// a held result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	// invalid pressure always reads zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.pressure_valid |-> out_data.pressure_pa == 32'd0)
		else $error("invalid pressure not zero");
	// a stall freezes the first and the last stage
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_s12))
		else $error("pipeline moved during stall");
endmodule

// File: test/baro_temp_pressure_compensation_core_chk.sv
`timescale 1ns / 100ps

module baro_temp_pressure_compensation_core_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  btpc_pkg::in_t                 in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  btpc_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic [btpc_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [btpc_pkg::CfgDataW-1:0] cfg_data,
	output int                            errors,
	output int                            pending
);
	import btpc_pkg::*;

	logic [15:0] t1, t2w, t3w, p1;
	logic [47:0] p234, p789;
	logic [31:0] p56;
	out_t        comp_q[$];

	function automatic logic [31:0] sra(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sw(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] lo(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] w;
		w = {32'd0, a} * {32'd0, b};
		return w[31:0];
	endfunction

	// compensated reading for one raw pair
	function automatic out_t compensate(input in_t r);
		logic [31:0] at, ap, a, b, d, fine, sq, p, dv;
		out_t o;
		at = {12'd0, r.temperature_raw};
		ap = {12'd0, r.pressure_raw};
		a = sra(lo((at >> 3) - ({16'd0, t1} << 1), sw(t2w)), 11);
		d = (at >> 4) - {16'd0, t1};
		b = sra(lo(sra(lo(d, d), 12), sw(t3w)), 14);
		fine = a + b;
		o.fine_temperature = fine;
		o.temperature_centi = sra(lo(fine, 32'd5) + 32'd128, 8);
		a = sra(fine, 1) - 32'd64000;
		sq = lo(sra(a, 2), sra(a, 2));
		b = lo(sra(sq, 11), sw(p56[31:16]));
		b = b + (lo(a, sw(p56[15:0])) << 1);
		b = sra(b, 2) + (sw(p234[47:32]) << 16);
		dv = sra(sra(lo(sw(p234[31:16]), sra(sq, 13)), 3) + sra(lo(sw(p234[15:0]), a), 1), 18);
		dv = sra(lo(32'd32768 + dv, {16'd0, p1}), 15);
		if (dv == 0) begin
			o.pressure_pa = '0;
			o.pressure_valid = 1'b0;
		end else begin
			p = lo((32'd1048576 - ap) - sra(b, 12), 32'd3125);
			if (p < 32'h8000_0000) p = (p << 1) / dv;
			else p = (p / dv) * 32'd2;
			a = sra(lo(sw(p789[47:32]), lo(p >> 3, p >> 3) >> 13), 12);
			b = sra(lo(p >> 2, sw(p789[31:16])), 13);
			o.pressure_pa = p + sra(a + b + sw(p789[15:0]), 4);
			o.pressure_valid = 1'b1;
		end
		return o;
	endfunction

	assign pending = comp_q.size();

	// calibration shadow, prediction and comparison
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			t1 <= '0; t2w <= '0; t3w <= '0; p1 <= '0;
			p234 <= '0; p56 <= '0; p789 <= '0;
			comp_q.delete();
			errors <= 0;
		end else begin
			if (in_valid && in_ready) comp_q.push_back(compensate(in_data));
			if (out_valid && out_ready) begin
				if (comp_q.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10) $display("unexpected result %p", out_data);
				end else begin
					want = comp_q.pop_front();
					if (want !== out_data) begin
						errors <= errors + 1;
						if (errors < 10) $display("mismatch exp %p got %p", want, out_data);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_T1:   t1 <= cfg_data[15:0];
					REG_T2:   t2w <= cfg_data[15:0];
					REG_T3:   t3w <= cfg_data[15:0];
					REG_P1:   p1 <= cfg_data[15:0];
					REG_P234: p234 <= cfg_data;
					REG_P56:  p56 <= cfg_data[31:0];
					REG_P789: p789 <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

// File: test/baro_temp_pressure_compensation_core_tb.sv
`timescale 1ns / 100ps

module baro_temp_pressure_compensation_core_tb;
	import btpc_pkg::*;

	localparam int Latency = 45;
	localparam int IdleLimit = 20000;

	logic clk, arst_n, in_valid, in_ready, out_valid, out_ready, cfg_we;
	in_t  in_data;
	out_t out_data;
	logic [CfgIdxW-1:0]  cfg_idx;
	logic [CfgDataW-1:0] cfg_data;
	int   errors, pending, idle_cycles;
	bit   hold_sink, sink_on;

	baro_temp_pressure_compensation_core dut (.*);

	baro_temp_pressure_compensation_core_chk chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off
	initial begin
		int w;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_sink = 1'b0;
			end
			w = sink_on ? 0 : $urandom_range(0, 17);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic write_cal(input logic [CfgIdxW-1:0] r, input logic [CfgDataW-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_idx <= r; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drain pipeline before touching calibration
	task automatic settle();
		while (pending != 0) @(negedge clk);
		repeat (Latency + 5) @(negedge clk);
	endtask

	task automatic send_pair(input logic [19:0] tr, input logic [19:0] pr, input bit gap);
		int w;
		w = gap ? $urandom_range(0, 17) : 0;
		@(negedge clk);
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w - 1) @(negedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{temperature_raw: tr, pressure_raw: pr};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// typical datasheet-like calibration with random spread
	task automatic typical_cal();
		write_cal(REG_T1, 48'd27504 + $urandom_range(0, 2000));
		write_cal(REG_T2, 48'd26435 + $urandom_range(0, 2000));
		write_cal(REG_T3, 48'(16'(-1000 - $urandom_range(0, 200))));
		write_cal(REG_P1, 48'd36477 + $urandom_range(0, 2000));
		write_cal(REG_P234, {16'd2855, 16'd3024, 16'(-10685)});
		write_cal(REG_P56, 48'({16'(-7), 16'd140}));
		write_cal(REG_P789, {16'd6000, 16'(-14600), 16'd15500});
	endtask

	task automatic random_cal();
		write_cal(REG_T1, 48'($urandom));
		write_cal(REG_T2, 48'($urandom));
		write_cal(REG_T3, 48'($urandom));
		write_cal(REG_P1, 48'($urandom));
		write_cal(REG_P234, {16'($urandom), 32'($urandom)});
		write_cal(REG_P56, 48'($urandom));
		write_cal(REG_P789, {16'($urandom), 32'($urandom)});
	endtask

	initial begin
		logic [19:0] tv, pv;
		in_valid = 1'b0; in_data = '0;
		cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
		hold_sink = 1'b0; sink_on = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset calibration: divisor zero, pressure invalid
		send_pair(20'd0, 20'd0, 1'b0);
		send_pair(20'hFFFFF, 20'hFFFFF, 1'b0);
		idle_input();
		settle();

		// typical calibration, field extremes
		typical_cal();
		send_pair(20'd519888, 20'd415148, 1'b0);
		send_pair(20'd0, 20'hFFFFF, 1'b1);
		send_pair(20'hFFFFF, 20'd0, 1'b1);
		send_pair(20'h55555, 20'hAAAAA, 1'b0);
		send_pair(20'hAAAAA, 20'h55555, 1'b0);
		idle_input();
		settle();

		// extreme calibration words
		write_cal(REG_T1, 48'hFFFF);
		write_cal(REG_T2, 48'h7FFF);
		write_cal(REG_T3, 48'h8000);
		write_cal(REG_P1, 48'hFFFF);
		write_cal(REG_P234, 48'h8000_7FFF_8000);
		write_cal(REG_P56, 48'h7FFF_8000);
		write_cal(REG_P789, 48'hFFFF_FFFF_FFFF);
		write_cal(3'd7, 48'h1234);
		send_pair(20'd0, 20'd0, 1'b0);
		send_pair(20'hFFFFF, 20'hFFFFF, 1'b0);
		send_pair(20'd519888, 20'd415148, 1'b0);
		idle_input();
		settle();

		// zero divisor with non-zero other words
		typical_cal();
		write_cal(REG_P1, 48'd0);
		send_pair(20'd519888, 20'd415148, 1'b0);
		send_pair(20'd12345, 20'd999, 1'b0);
		idle_input();
		settle();

		// random phases; one back-to-back burst against a held-off sink
		for (int ph = 0; ph < 8; ph++) begin
			if (ph % 3 == 2) random_cal();
			else typical_cal();
			if (ph == 1) hold_sink = 1'b1;
			sink_on = (ph == 4);
			for (int i = 0; i < 90; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					tv = 20'($urandom); pv = 20'($urandom);
				end else begin
					tv = 20'd400000 + 20'($urandom_range(0, 250000));
					pv = 20'd250000 + 20'($urandom_range(0, 300000));
				end
				send_pair(tv, pv, !(ph == 1 || ph == 4));
			end
			idle_input();
			settle();
		end
		sink_on = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (Latency + 10) @(negedge clk);
		if (errors == 0 && pending == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
